// ===== src/xtea_pkg.sv =====
// shared types, constants and the round mixing function for the xtea core
// no dependencies
package xtea_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BLOCK_W = 2 * WORD_W;
  localparam int unsigned KEY_W   = 4 * WORD_W;
  localparam int unsigned IDX_W   = 2;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic [IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
  } stage_t;

  function automatic logic [WORD_W-1:0] mix(
    input logic [WORD_W-1:0] v,
    input logic [WORD_W-1:0] s,
    input logic [WORD_W-1:0] k
  );
    logic [WORD_W-1:0] f;
    f = ((v << 4) ^ (v >> 5)) + v;
    return f ^ (s + k);
  endfunction

endpackage

// ===== src/xtea_block_cipher_core.sv =====
// pipelined xtea encrypt/decrypt core, one half-round per pipeline stage
// depends on xtea_pkg
//
// Encrypts or decrypts one 64-bit block per transfer with XTEA under a 128-bit key
// written through the cfg port (index 0..3 = key word 0..3, reset to zero). The
// pipeline has 2*ROUNDS stages, one Feistel half-round each, and every stage is
// registered; the output is driven from the last stage register. A new block is
// taken every cycle unless the input is stalled. Empty stages are filled while the
// output waits, so the input stalls only once all 2*ROUNDS stages hold blocks.
// Write the key only while no block is in flight.
module xtea_block_cipher_core #(
  parameter int unsigned ROUNDS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [31:0] in_word0, [63:32] in_word1
  input  logic [xtea_pkg::BLOCK_W-1:0] in_tdata,
  // [0] mode (0 encrypt, 1 decrypt)
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [31:0] out_word0, [63:32] out_word1
  output logic [xtea_pkg::BLOCK_W-1:0] out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [xtea_pkg::IDX_W-1:0]   cfg_index,
  input  logic [xtea_pkg::WORD_W-1:0]  cfg_data
);

  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam logic [63:0] DEC_SUM_FULL = 64'(xtea_pkg::DELTA) * 64'(ROUNDS);
  localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = DEC_SUM_FULL[xtea_pkg::WORD_W-1:0];

  logic [xtea_pkg::KEY_W-1:0] key_r;
  xtea_pkg::stage_t           st_r   [STAGES];
  xtea_pkg::stage_t           st_nxt [STAGES];
  xtea_pkg::stage_t           src    [STAGES];
  logic [STAGES-1:0]          vld_r;
  logic [STAGES-1:0]          src_vld;
  logic [STAGES:0]            rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        xtea_pkg::REG_KEY_WORD0: key_r[31:0]   <= cfg_data;
        xtea_pkg::REG_KEY_WORD1: key_r[63:32]  <= cfg_data;
        xtea_pkg::REG_KEY_WORD2: key_r[95:64]  <= cfg_data;
        xtea_pkg::REG_KEY_WORD3: key_r[127:96] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy[STAGES] = out_tready;
  assign in_tready   = rdy[0];
  assign out_tvalid  = vld_r[STAGES-1];
  assign out_tdata   = {st_r[STAGES-1].word1, st_r[STAGES-1].word0};

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic                        use_hi;
    logic [1:0]                  ksel;
    logic [xtea_pkg::WORD_W-1:0] kw;
    logic [xtea_pkg::WORD_W-1:0] m;

    if (i == 0) begin : g_first
      assign src_vld[i]   = in_tvalid;
      assign src[i].mode  = in_tuser;
      assign src[i].sum   = (in_tuser == xtea_pkg::MODE_DECRYPT) ? DEC_SUM : '0;
      assign src[i].word0 = in_tdata[31:0];
      assign src[i].word1 = in_tdata[63:32];
    end else begin : g_rest
      assign src_vld[i] = vld_r[i-1];
      assign src[i]     = st_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    // even stages: encrypt updates word0, decrypt updates word1; odd stages the reverse
    if ((i % 2) == 0) begin : g_even
      assign use_hi = src[i].mode;
    end else begin : g_odd
      assign use_hi = !src[i].mode;
    end

    assign ksel = use_hi ? src[i].sum[12:11] : src[i].sum[1:0];
    assign kw   = key_r[{ksel, 5'b0} +: xtea_pkg::WORD_W];
    assign m    = xtea_pkg::mix(use_hi ? src[i].word0 : src[i].word1, src[i].sum, kw);

    always_comb begin
      st_nxt[i] = src[i];
      if (use_hi) begin
        st_nxt[i].word1 = src[i].mode ? src[i].word1 - m : src[i].word1 + m;
      end else begin
        st_nxt[i].word0 = src[i].mode ? src[i].word0 - m : src[i].word0 + m;
      end
      if ((i % 2) == 0) begin
        st_nxt[i].sum = src[i].mode ? src[i].sum - xtea_pkg::DELTA
                                    : src[i].sum + xtea_pkg::DELTA;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= src_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_vld[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

endmodule

// ===== src/xtea_chk.sv =====
// port-level checker for xtea_block_cipher_core, attached by bind
// depends on xtea_pkg and xtea_block_cipher_core
module xtea_chk #(
  parameter int unsigned ROUNDS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [xtea_pkg::BLOCK_W-1:0] out_tdata
);

  localparam int unsigned STAGES = 2 * ROUNDS;
  localparam int unsigned CNT_W  = $clog2(STAGES + 2);

  logic [CNT_W-1:0] cnt_r;
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (!in_xfer && out_xfer) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid |-> cnt_r != '0) and (cnt_r <= CNT_W'(STAGES)))
    else $error("result without a matching input transfer or overfull pipeline");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && cnt_r == CNT_W'(STAGES))
    else $error("input stalled while the pipeline has room");

endmodule

bind xtea_block_cipher_core xtea_chk #(.ROUNDS(ROUNDS)) u_xtea_chk (.*);
